>>> sv/i2cmbs_pkg.sv
package i2cmbs_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ACK_NONE    = 2'd0,
    ACK_OK      = 2'd1,
    ACK_TIMEOUT = 2'd2
  } ack_t;

  // register index, taken from paddr[2]
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd10;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd8000;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  // sequence steps
  localparam logic [3:0] STEP_FIRST       = 4'd0;
  localparam logic [3:0] STEP_ST_SDA_REL  = 4'd1;
  localparam logic [3:0] STEP_ST_SDA_LOW  = 4'd2;
  localparam logic [3:0] STEP_ST_LAST     = 4'd3;
  localparam logic [3:0] STEP_SP_SCL_HIGH = 4'd1;
  localparam logic [3:0] STEP_SP_LAST     = 4'd2;
  localparam logic [3:0] STEP_WR_BIT_DATA = 4'd1;
  localparam logic [3:0] STEP_WR_BIT_HIGH = 4'd2;
  localparam logic [3:0] STEP_WR_ACK_LOW  = 4'd3;
  localparam logic [3:0] STEP_WR_ACK_REL  = 4'd5;
  localparam logic [3:0] STEP_WR_ACK_HIGH = 4'd6;
  localparam logic [3:0] STEP_WR_POLL     = 4'd7;
  localparam logic [3:0] STEP_WR_END      = 4'd8;
  localparam logic [3:0] STEP_RD_HIGH     = 4'd1;
  localparam logic [3:0] STEP_RD_LOW      = 4'd2;
  localparam logic [3:0] STEP_RD_ACK_LOW  = 4'd3;
  localparam logic [3:0] STEP_RD_ACK_DRV  = 4'd4;
  localparam logic [3:0] STEP_RD_ACK_HIGH = 4'd5;
  localparam logic [3:0] STEP_RD_LAST     = 4'd6;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       timed_out;
    logic       rejected;
  } res_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  step;
    logic [3:0]  bitpos;
    logic [7:0]  shift;
    logic [15:0] pc;
    logic [15:0] awc;
    logic        scl;
    logic        sda;
    logic [7:0]  rxb;
    ack_t        ack;
  } core_t;

endpackage

>>> sv/i2c_master_byte_sequencer_core.sv
// channel   | handshake                  | payload
// request   | req_valid / req_stall      | req_data  (func, tx_byte, sda_in)
// result    | res_valid / res_stall      | res_data  (line drive, status, rx_byte)
// config    | psel penable pwrite pready | paddr, pwdata, prdata
//
// one request per clock while req_stall is low, one result per request: the
// sequencer state and the result register are both loaded from the same
// combinational step. a request is taken while a result waits, as long as
// that result leaves in the same cycle. rst is synchronous and returns the
// lines to released, the command to idle and the registers to their defaults.
module i2c_master_byte_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  i2cmbs_pkg::req_t   req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output i2cmbs_pkg::res_t   res_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import i2cmbs_pkg::*;

  logic [15:0] phase_ticks;
  logic [15:0] ack_timeout;
  core_t       st;
  core_t       st_next;
  res_t        res_next;
  logic        req_take;
  logic        cfg_wr;

  function automatic core_t enter_step(core_t c, logic [3:0] s);
    core_t r;
    r = c;
    r.step = s;
    r.pc = '0;
    case (c.cmd)
      CMD_START: begin
        if (s == STEP_FIRST) r.scl = 1'b1;
        else if (s == STEP_ST_SDA_REL) r.sda = 1'b1;
        else if (s == STEP_ST_SDA_LOW) r.sda = 1'b0;
        else r.scl = 1'b0;
      end
      CMD_STOP: begin
        if (s == STEP_FIRST) r.sda = 1'b0;
        else if (s == STEP_SP_SCL_HIGH) r.scl = 1'b1;
        else r.sda = 1'b1;
      end
      CMD_WRITE: begin
        if (s == STEP_WR_BIT_DATA) begin
          r.sda = c.shift[7];
          r.shift = {c.shift[6:0], 1'b0};
        end else if (s == STEP_WR_BIT_HIGH || s == STEP_WR_ACK_HIGH) begin
          r.scl = 1'b1;
        end else if (s == STEP_WR_ACK_REL) begin
          r.sda = 1'b1;
        end else if (s == STEP_WR_POLL) begin
          r.awc = '0;
        end else begin
          r.scl = 1'b0;
        end
      end
      CMD_READ_ACK, CMD_READ_NACK: begin
        if (s == STEP_RD_HIGH) begin
          r.sda = 1'b1;
          r.scl = 1'b1;
        end else if (s == STEP_RD_ACK_DRV) begin
          r.sda = (c.cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
        end else if (s == STEP_RD_ACK_HIGH) begin
          r.scl = 1'b1;
        end else begin
          r.scl = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always_comb begin
    core_t       c;
    logic        rej;
    logic        done;
    logic        scl_now;
    logic        sda_now;
    logic [3:0]  nbit;
    c = st;
    rej = 1'b0;
    done = 1'b0;
    nbit = '0;

    // command decode, codes 0, 6 and 7 are plain ticks
    if (req_data.func >= CMD_START && req_data.func <= CMD_READ_NACK) begin
      if (c.cmd != CMD_IDLE) begin
        rej = 1'b1;
      end else begin
        c.cmd = cmd_t'(req_data.func);
        c.bitpos = '0;
        c.shift = (req_data.func == CMD_WRITE) ? req_data.tx_byte : 8'h00;
        if (req_data.func == CMD_WRITE) c.ack = ACK_NONE;
        c = enter_step(c, STEP_FIRST);
      end
    end

    scl_now = c.scl;
    sda_now = c.sda;

    if (c.cmd != CMD_IDLE) begin
      if (c.cmd == CMD_WRITE && c.step == STEP_WR_POLL) begin
        if (!req_data.sda_in) begin
          c.ack = ACK_OK;
          c = enter_step(c, STEP_WR_END);
        end else if (c.awc >= ack_timeout) begin
          // timeout stop begins with scl still high
          c.ack = ACK_TIMEOUT;
          c.cmd = CMD_STOP;
          c = enter_step(c, STEP_FIRST);
        end else begin
          c.awc = c.awc + 16'd1;
        end
      end else begin
        c.pc = c.pc + 16'd1;
        if (c.pc >= phase_ticks) begin
          case (c.cmd)
            CMD_START: begin
              if (c.step < STEP_ST_LAST) c = enter_step(c, c.step + 4'd1);
              else done = 1'b1;
            end
            CMD_STOP: begin
              if (c.step < STEP_SP_LAST) c = enter_step(c, c.step + 4'd1);
              else done = 1'b1;
            end
            CMD_WRITE: begin
              if (c.step == STEP_WR_BIT_HIGH) begin
                nbit = c.bitpos + 4'd1;
                c.bitpos = nbit;
                c = enter_step(c, (nbit < BYTE_BITS) ? STEP_FIRST : STEP_WR_ACK_LOW);
              end else if (c.step >= STEP_WR_END) begin
                done = 1'b1;
              end else begin
                c = enter_step(c, c.step + 4'd1);
              end
            end
            CMD_READ_ACK, CMD_READ_NACK: begin
              if (c.step == STEP_RD_HIGH) begin
                c.shift = {c.shift[6:0], req_data.sda_in};
                c = enter_step(c, STEP_RD_LOW);
              end else if (c.step == STEP_RD_LOW) begin
                nbit = c.bitpos + 4'd1;
                c.bitpos = nbit;
                if (nbit < BYTE_BITS) begin
                  c = enter_step(c, STEP_RD_HIGH);
                end else begin
                  c.rxb = c.shift;
                  c = enter_step(c, STEP_RD_ACK_LOW);
                end
              end else if (c.step >= STEP_RD_LAST) begin
                done = 1'b1;
              end else begin
                c = enter_step(c, c.step + 4'd1);
              end
            end
            default: done = 1'b1;
          endcase
          if (done) begin
            c.cmd = CMD_IDLE;
            c.step = STEP_FIRST;
            c.pc = '0;
          end
        end
      end
    end

    st_next = c;
    res_next.scl_out   = scl_now;
    res_next.sda_out   = sda_now;
    res_next.busy_res  = (c.cmd != CMD_IDLE);
    res_next.done_res  = done;
    res_next.rx_byte   = c.rxb;
    res_next.ack_ok    = (c.ack == ACK_OK);
    res_next.timed_out = (c.ack == ACK_TIMEOUT);
    res_next.rejected  = rej;
  end

  assign req_stall = res_valid && res_stall;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.cmd    <= CMD_IDLE;
      st.step   <= STEP_FIRST;
      st.bitpos <= '0;
      st.shift  <= '0;
      st.pc     <= '0;
      st.awc    <= '0;
      st.scl    <= 1'b1;
      st.sda    <= 1'b1;
      st.rxb    <= '0;
      st.ack    <= ACK_NONE;
      res_valid <= 1'b0;
    end else if (req_take) begin
      st        <= st_next;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) res_data <= res_next;
  end

  // config port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RST;
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PHASE_TICKS) phase_ticks <= pwdata[15:0];
      else ack_timeout <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_ACK_TIMEOUT) prdata = {16'h0000, ack_timeout};
    else prdata = {16'h0000, phase_ticks};
  end

endmodule

>>> sv/i2cmbs_checker.sv
module i2cmbs_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_stall,
  input logic             res_valid,
  input logic             res_stall,
  input i2cmbs_pkg::res_t res_data,
  input logic             pready
);
  import i2cmbs_pkg::*;

  // a held result keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // every taken request yields a result on the next cycle
  a_req_to_res: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> res_valid)
    else $error("request taken without a result");

  // a finished command leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.done_res |-> !res_data.busy_res)
    else $error("done reported while still busy");

  a_ack_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.ack_ok && res_data.timed_out))
    else $error("ack and timeout reported together");

  a_rdy: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port inserted a wait state");

endmodule

bind i2c_master_byte_sequencer_core i2cmbs_checker u_i2cmbs_checker (.*);
